// ===== sv/wov_pkg.sv =====
// Shared types and constants for the waveform overview block.
`timescale 1ns / 1ps
`default_nettype none
package wov_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int IDX_W       = 12;
    localparam int NCFG_W      = 21;
    localparam int WCFG_W      = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CNTR_W      = 20;
    localparam int BINCNT_W    = 21;
    localparam int ACC_W       = 33;
    localparam int PROD_W      = 34;
    localparam int SQ_W        = 32;
    // a full-scale bin of 2^20 samples sums to 2^50; keep the width even for the root
    localparam int SUM_W       = 52;
    localparam int RMS_W       = 16;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [NCFG_W-1:0] MAX_SAMPLES = NCFG_W'(1048576);
    localparam logic [WCFG_W-1:0] MAX_PIXELS  = WCFG_W'(4096);

    localparam logic [NCFG_W-1:0] RST_NUM_SAMPLES = NCFG_W'(1024);
    localparam logic [WCFG_W-1:0] RST_NUM_PIXELS  = WCFG_W'(300);
    localparam logic [NCFG_W-1:0] RST_SPP         = NCFG_W'(4);

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PIXELS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPP         = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0]           index;
        logic signed [SAMPLE_W-1:0] vmin;
        logic signed [SAMPLE_W-1:0] vmax;
        logic [SUM_W-1:0]           sum;
        logic [BINCNT_W-1:0]        count;
        logic                       last;
    } bin_rec_t;

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_UPD, F_EMIT} front_state_t;
    typedef enum logic [1:0] {B_IDLE, B_DIV, B_SQRT, B_OUT} back_state_t;

endpackage
`default_nettype wire

// ===== sv/wov_if.sv =====
// Channel interfaces: sample input, result output and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface wov_sample_if;
    logic                               valid;
    logic                               ready;
    logic signed [wov_pkg::SAMPLE_W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface wov_result_if;
    logic                               valid;
    logic                               ready;
    logic [wov_pkg::IDX_W-1:0]          pixel_index;
    logic signed [wov_pkg::SAMPLE_W-1:0] bin_min;
    logic signed [wov_pkg::SAMPLE_W-1:0] bin_max;
    logic [wov_pkg::RMS_W-1:0]          rms_level;
    logic                               last;
    modport source (output valid, output pixel_index, output bin_min, output bin_max,
                    output rms_level, output last, input ready);
    modport sink (input valid, input pixel_index, input bin_min, input bin_max,
                  input rms_level, input last, output ready);
endinterface

interface wov_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [wov_pkg::CFG_IDX_W-1:0]     index;
    logic [wov_pkg::NCFG_W-1:0]        data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/wov_fifo.sv =====
// Short queue of closed-bin records between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module wov_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire wov_pkg::bin_rec_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output wov_pkg::bin_rec_t      pop_data,
    output logic                   empty
);

    wov_pkg::bin_rec_t              mem_reg [wov_pkg::QDEPTH];
    logic [wov_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [wov_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [wov_pkg::QCNT_W-1:0]     count_reg, count_next;

    function automatic logic [wov_pkg::QPTR_W-1:0] QPTR_ONE(input logic b);
        return wov_pkg::QPTR_W'(b);
    endfunction

    assign full     = (count_reg == wov_pkg::QCNT_W'(wov_pkg::QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_ONE(push);
        rd_ptr_next = rd_ptr_reg + QPTR_ONE(pop);
        count_next  = count_reg + wov_pkg::QCNT_W'(push) - wov_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= wov_pkg::QCNT_W'(wov_pkg::QDEPTH))
        else $error("queue count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== sv/wov_front.sv =====
// Front end: register file, bin scheduling and the two open-bin accumulators.
`timescale 1ns / 1ps
`default_nettype none
module wov_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    wov_sample_if.sink       samples,
    wov_cfg_if.sink          cfg,
    output logic             push,
    output wov_pkg::bin_rec_t push_data,
    input  wire logic        full
);

    typedef struct packed {
        logic                               valid;
        logic [wov_pkg::IDX_W-1:0]          index;
        logic signed [wov_pkg::SAMPLE_W-1:0] vmin;
        logic signed [wov_pkg::SAMPLE_W-1:0] vmax;
        logic [wov_pkg::SUM_W-1:0]          sum;
        logic [wov_pkg::BINCNT_W-1:0]       count;
    } slot_t;

    localparam logic signed [wov_pkg::SAMPLE_W-1:0] FS_POS = {1'b0, {(wov_pkg::SAMPLE_W-1){1'b1}}};
    localparam logic signed [wov_pkg::SAMPLE_W-1:0] FS_NEG = {1'b1, {(wov_pkg::SAMPLE_W-1){1'b0}}};
    localparam slot_t SLOT_CLR = '{valid: 1'b0, index: '0, vmin: FS_POS, vmax: FS_NEG,
                                   sum: '0, count: '0};

    wov_pkg::front_state_t              state_reg, state_next;
    logic [wov_pkg::NCFG_W-1:0]         num_samples_reg;
    logic [wov_pkg::WCFG_W-1:0]         num_pixels_reg;
    logic [wov_pkg::NCFG_W-1:0]         spp_reg;
    logic signed [wov_pkg::SAMPLE_W-1:0] sample_reg;
    logic [wov_pkg::SQ_W-1:0]           sq_reg;
    logic [wov_pkg::PROD_W-1:0]         prod_reg;
    logic [wov_pkg::CNTR_W-1:0]         counter_reg, counter_next;
    logic [wov_pkg::WCFG_W-1:0]         next_bin_reg, next_bin_next;
    logic [wov_pkg::ACC_W-1:0]          acc_reg, acc_next;
    slot_t                              slot_reg [2];
    slot_t                              slot_next [2];
    wov_pkg::bin_rec_t                  rec_reg [2];
    wov_pkg::bin_rec_t                  rec_next [2];
    logic [1:0]                         nrec_reg, nrec_next;
    logic                               ptr_reg;

    logic [wov_pkg::NCFG_W-1:0]         n_c, len_c;
    logic [wov_pkg::WCFG_W-1:0]         w_c;
    logic                               at_end, open_ok, swap;
    logic [1:0]                         close;
    logic signed [wov_pkg::SQ_W-1:0]    sq_full;

    // clamp registers into their legal ranges
    always_comb
    begin
        n_c = num_samples_reg;
        if (num_samples_reg < wov_pkg::NCFG_W'(2))
            n_c = wov_pkg::NCFG_W'(2);
        else if (num_samples_reg > wov_pkg::MAX_SAMPLES)
            n_c = wov_pkg::MAX_SAMPLES;
        w_c = num_pixels_reg;
        if (num_pixels_reg < wov_pkg::WCFG_W'(2))
            w_c = wov_pkg::WCFG_W'(2);
        else if (num_pixels_reg > wov_pkg::MAX_PIXELS)
            w_c = wov_pkg::MAX_PIXELS;
        len_c = spp_reg;
        if (spp_reg == '0)
            len_c = wov_pkg::NCFG_W'(1);
        else if (spp_reg > wov_pkg::MAX_SAMPLES)
            len_c = wov_pkg::MAX_SAMPLES;
    end

    assign sq_full   = wov_pkg::SQ_W'(sample_reg) * wov_pkg::SQ_W'(sample_reg);
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_samples_reg <= wov_pkg::RST_NUM_SAMPLES;
            num_pixels_reg  <= wov_pkg::RST_NUM_PIXELS;
            spp_reg         <= wov_pkg::RST_SPP;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                wov_pkg::CFG_NUM_SAMPLES: num_samples_reg <= cfg.data;
                wov_pkg::CFG_NUM_PIXELS:  num_pixels_reg  <= cfg.data[wov_pkg::WCFG_W-1:0];
                wov_pkg::CFG_SPP:         spp_reg         <= cfg.data;
                default: ;
            endcase
        end
    end

    // bin bookkeeping for the latched sample
    always_comb
    begin
        slot_next[0]  = slot_reg[0];
        slot_next[1]  = slot_reg[1];
        acc_next      = acc_reg;
        next_bin_next = next_bin_reg;
        rec_next[0]   = rec_reg[0];
        rec_next[1]   = rec_reg[1];
        nrec_next     = 2'd0;
        swap          = 1'b0;
        close         = 2'b00;
        at_end        = {1'b0, counter_reg} >= (n_c - wov_pkg::NCFG_W'(1));
        open_ok       = (next_bin_reg < w_c) &&
                        (wov_pkg::PROD_W'(acc_reg) < prod_reg);

        if (open_ok && (!slot_reg[0].valid || !slot_reg[1].valid))
        begin
            if (!slot_reg[0].valid)
            begin
                slot_next[0]       = SLOT_CLR;
                slot_next[0].valid = 1'b1;
                slot_next[0].index = next_bin_reg[wov_pkg::IDX_W-1:0];
            end
            else
            begin
                slot_next[1]       = SLOT_CLR;
                slot_next[1].valid = 1'b1;
                slot_next[1].index = next_bin_reg[wov_pkg::IDX_W-1:0];
            end
            acc_next      = acc_reg + wov_pkg::ACC_W'(n_c - wov_pkg::NCFG_W'(1));
            next_bin_next = next_bin_reg + wov_pkg::WCFG_W'(1);
        end

        for (int s = 0; s < 2; s++)
        begin
            if (slot_next[s].valid)
            begin
                if (sample_reg < slot_next[s].vmin)
                    slot_next[s].vmin = sample_reg;
                if (sample_reg > slot_next[s].vmax)
                    slot_next[s].vmax = sample_reg;
                slot_next[s].sum   = slot_next[s].sum + wov_pkg::SUM_W'(sq_reg);
                slot_next[s].count = slot_next[s].count + wov_pkg::BINCNT_W'(1);
                close[s] = at_end || (slot_next[s].count >= len_c);
            end
        end

        // lower pixel index goes out first
        swap = close[0] && close[1] && (slot_next[1].index < slot_next[0].index);
        if (close[0] && close[1])
        begin
            nrec_next = 2'd2;
            rec_next[0] = '{index: slot_next[swap ? 1 : 0].index,
                            vmin:  slot_next[swap ? 1 : 0].vmin,
                            vmax:  slot_next[swap ? 1 : 0].vmax,
                            sum:   slot_next[swap ? 1 : 0].sum,
                            count: slot_next[swap ? 1 : 0].count, last: 1'b0};
            rec_next[1] = '{index: slot_next[swap ? 0 : 1].index,
                            vmin:  slot_next[swap ? 0 : 1].vmin,
                            vmax:  slot_next[swap ? 0 : 1].vmax,
                            sum:   slot_next[swap ? 0 : 1].sum,
                            count: slot_next[swap ? 0 : 1].count, last: 1'b1};
        end
        else if (close[0] || close[1])
        begin
            nrec_next = 2'd1;
            rec_next[0] = '{index: slot_next[close[1] ? 1 : 0].index,
                            vmin:  slot_next[close[1] ? 1 : 0].vmin,
                            vmax:  slot_next[close[1] ? 1 : 0].vmax,
                            sum:   slot_next[close[1] ? 1 : 0].sum,
                            count: slot_next[close[1] ? 1 : 0].count, last: 1'b1};
        end
        if (close[0])
            slot_next[0] = SLOT_CLR;
        if (close[1])
            slot_next[1] = SLOT_CLR;

        if (at_end)
        begin
            counter_next  = '0;
            next_bin_next = '0;
            acc_next      = '0;
        end
        else
        begin
            counter_next = counter_reg + wov_pkg::CNTR_W'(1);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        samples.ready = 1'b0;
        push          = 1'b0;
        push_data     = rec_reg[ptr_reg];
        unique case (state_reg)
            wov_pkg::F_IDLE:
            begin
                samples.ready = 1'b1;
                if (samples.valid)
                    state_next = wov_pkg::F_MUL;
            end
            wov_pkg::F_MUL:
                state_next = wov_pkg::F_UPD;
            wov_pkg::F_UPD:
                state_next = (nrec_next == 2'd0) ? wov_pkg::F_IDLE : wov_pkg::F_EMIT;
            wov_pkg::F_EMIT:
            begin
                push = !full;
                if (!full && (!ptr_reg == (nrec_reg == 2'd1) || ptr_reg))
                    state_next = wov_pkg::F_IDLE;
            end
            default:
                state_next = wov_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= wov_pkg::F_IDLE;
            counter_reg  <= '0;
            next_bin_reg <= '0;
            acc_reg      <= '0;
            slot_reg[0]  <= SLOT_CLR;
            slot_reg[1]  <= SLOT_CLR;
            nrec_reg     <= 2'd0;
            ptr_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == wov_pkg::F_UPD)
            begin
                counter_reg  <= counter_next;
                next_bin_reg <= next_bin_next;
                acc_reg      <= acc_next;
                slot_reg[0]  <= slot_next[0];
                slot_reg[1]  <= slot_next[1];
                nrec_reg     <= nrec_next;
                ptr_reg      <= 1'b0;
            end
            else if (push)
            begin
                ptr_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
            sample_reg <= samples.sample;
        if (state_reg == wov_pkg::F_MUL)
        begin
            sq_reg   <= wov_pkg::SQ_W'(sq_full);
            prod_reg <= wov_pkg::PROD_W'({1'b0, counter_reg} + wov_pkg::NCFG_W'(1))
                        * wov_pkg::PROD_W'(w_c - wov_pkg::WCFG_W'(1));
        end
        if (state_reg == wov_pkg::F_UPD)
        begin
            rec_reg[0] <= rec_next[0];
            rec_reg[1] <= rec_next[1];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wov_pkg::F_EMIT) |-> (nrec_reg != 2'd0))
        else $error("emitting with no closed bin");
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (state_reg == wov_pkg::F_EMIT))
        else $error("push outside the emit state");
    assert property (@(posedge clk) disable iff (!rst_n)
        samples.ready |-> (state_reg == wov_pkg::F_IDLE))
        else $error("sample ready while busy");

endmodule
`default_nettype wire

// ===== sv/wov_back.sv =====
// Back end: mean of squares by shift-subtract division, then digit-by-digit square root.
`timescale 1ns / 1ps
`default_nettype none
module wov_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    output logic                  pop,
    input  wire wov_pkg::bin_rec_t pop_data,
    input  wire logic             empty,
    wov_result_if.source          results
);

    localparam int ROOT_STEPS = wov_pkg::SUM_W / 2;
    localparam int STEP_W     = 6;
    localparam int SREM_W     = ROOT_STEPS + 3;

    wov_pkg::back_state_t               state_reg, state_next;
    wov_pkg::bin_rec_t                  rec_reg;
    logic [wov_pkg::SUM_W-1:0]          quot_reg;
    logic [wov_pkg::BINCNT_W-1:0]       drem_reg;
    logic [SREM_W-1:0]                  srem_reg;
    logic [ROOT_STEPS:0]                root_reg;
    logic [STEP_W-1:0]                  step_reg;

    logic [wov_pkg::BINCNT_W:0]         drem_sh;
    logic [SREM_W-1:0]                  srem_sh, trial;
    logic                               div_last, sqrt_last;

    assign drem_sh   = {drem_reg, quot_reg[wov_pkg::SUM_W-1]};
    assign srem_sh   = {srem_reg[SREM_W-3:0], quot_reg[wov_pkg::SUM_W-1 -: 2]};
    assign trial     = SREM_W'({root_reg, 2'b01});
    assign div_last  = (step_reg == STEP_W'(wov_pkg::SUM_W - 1));
    assign sqrt_last = (step_reg == STEP_W'(ROOT_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        unique case (state_reg)
            wov_pkg::B_IDLE:
            begin
                pop = !empty;
                if (!empty)
                    state_next = wov_pkg::B_DIV;
            end
            wov_pkg::B_DIV:
                if (div_last)
                    state_next = wov_pkg::B_SQRT;
            wov_pkg::B_SQRT:
                if (sqrt_last)
                    state_next = wov_pkg::B_OUT;
            wov_pkg::B_OUT:
                if (results.ready)
                    state_next = wov_pkg::B_IDLE;
            default:
                state_next = wov_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= wov_pkg::B_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            wov_pkg::B_IDLE:
            begin
                rec_reg  <= pop_data;
                quot_reg <= pop_data.sum;
                drem_reg <= '0;
                step_reg <= '0;
            end
            wov_pkg::B_DIV:
            begin
                if (drem_sh >= {1'b0, rec_reg.count})
                begin
                    drem_reg <= wov_pkg::BINCNT_W'(drem_sh - {1'b0, rec_reg.count});
                    quot_reg <= {quot_reg[wov_pkg::SUM_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= drem_sh[wov_pkg::BINCNT_W-1:0];
                    quot_reg <= {quot_reg[wov_pkg::SUM_W-2:0], 1'b0};
                end
                // empty bin reads as zero mean
                if (div_last && rec_reg.count == '0)
                    quot_reg <= '0;
                step_reg <= div_last ? '0 : step_reg + STEP_W'(1);
                srem_reg <= '0;
                root_reg <= '0;
            end
            wov_pkg::B_SQRT:
            begin
                if (srem_sh >= trial)
                begin
                    srem_reg <= srem_sh - trial;
                    root_reg <= {root_reg[ROOT_STEPS-1:0], 1'b1};
                end
                else
                begin
                    srem_reg <= srem_sh;
                    root_reg <= {root_reg[ROOT_STEPS-1:0], 1'b0};
                end
                quot_reg <= {quot_reg[wov_pkg::SUM_W-3:0], 2'b00};
                step_reg <= step_reg + STEP_W'(1);
            end
            wov_pkg::B_OUT: ;
            default: ;
        endcase
    end

    assign results.valid       = (state_reg == wov_pkg::B_OUT);
    assign results.pixel_index = rec_reg.index;
    assign results.bin_min     = rec_reg.vmin;
    assign results.bin_max     = rec_reg.vmax;
    assign results.rms_level   = root_reg[wov_pkg::RMS_W-1:0];
    assign results.last        = rec_reg.last;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wov_pkg::B_OUT) |-> (root_reg <= (ROOT_STEPS+1)'(32768)))
        else $error("rms above full scale");
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == wov_pkg::B_DIV))
        else $error("pop without starting division");
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.ready) |=> (results.valid && $stable(results.pixel_index)))
        else $error("result beat dropped while stalled");

endmodule
`default_nettype wire

// ===== sv/waveform_overview_min_max_rms_top.sv =====
// Waveform overview top level: min, max and RMS per display pixel.
//
// Channels: samples (one Q1.15 array sample per beat, index 0 first), results
// (one beat per closed pixel bin: index, min, max, rms, last) and cfg (register
// writes, index 0 num_samples, 1 num_pixels, 2 samples_per_pixel; always ready).
// A sample passes the front-end states idle, multiply and update, and each closed
// bin then enters the 4-entry record queue in the emit state, which stalls while
// the queue is full; a new sample is taken only back in the idle state.
// Each closed bin passes through the shift-subtract divider and then the
// square-root unit, then waits in the output register; the serial back end
// takes no new bin from the queue until that result is accepted.
// When the receiver stalls, results stay in the output register, the queue
// fills, and the front end then holds off further samples.
// Reset clears the counters and both open bins and loads the register
// defaults 1024, 300 and 4. After the last sample of an array all open bins
// close and the next beat starts a new array.
`timescale 1ns / 1ps
`default_nettype none
module waveform_overview_min_max_rms_top (
    input  wire logic     clk,
    input  wire logic     rst_n,
    wov_sample_if.sink    samples,
    wov_result_if.source  results,
    wov_cfg_if.sink       cfg
);

    logic              push, full, pop, empty;
    wov_pkg::bin_rec_t push_data, pop_data;

    wov_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .cfg       (cfg),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    wov_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    wov_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (empty),
        .results  (results)
    );

endmodule
`default_nettype wire
